/* rtl/core/owl_pkg.sv */
// Package for the ordered word list: request codes, field widths and the
// command struct broadcast from the control logic to the row of cells.
// No dependencies.
`timescale 1ns / 1ps

package owl_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned ACT_W = 3;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;

  // Request codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_INSERT  = 3'd3,
    ACT_DELETE  = 3'd4,
    ACT_READ    = 3'd5
  } action_t;

  // Command seen by every cell in the cycle a request is transferred.
  typedef struct packed {
    logic wr;   // Load the request word into the selected cell.
    logic ins;  // Cells above the selected position take their lower neighbor.
    logic del;  // The selected cell and those above take their upper neighbor.
    logic rd;   // The selected cell drives its word onto the read bus.
  } cell_cmd_t;

endpackage

/* rtl/core/owl_cell.sv */
// One storage cell of the ordered word list. It holds a single entry and
// shifts with its neighbors on insert and delete.
// Depends on owl_pkg.
`timescale 1ns / 1ps

module owl_cell #(
  parameter int unsigned POS    = 0,
  parameter int unsigned SEL_W  = 7
) (
  input  logic                      clk,
  input  owl_pkg::cell_cmd_t        cmd,
  input  logic [SEL_W-1:0]          sel_pos,
  input  logic [owl_pkg::VAL_W-1:0] wr_value,
  input  logic [owl_pkg::VAL_W-1:0] lower_data,
  input  logic [owl_pkg::VAL_W-1:0] upper_data,
  output logic [owl_pkg::VAL_W-1:0] data,
  output logic [owl_pkg::VAL_W-1:0] rd_data
);
  import owl_pkg::*;

  localparam logic [SEL_W-1:0] MY_POS = SEL_W'(POS);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic             match;
  logic             above;

  assign match = (sel_pos == MY_POS);
  assign above = (MY_POS > sel_pos);

  // Shift up on insert, shift down on delete, otherwise load or hold.
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && above) begin
      data_nxt = lower_data;
    end else if (cmd.del && (above || match)) begin
      data_nxt = upper_data;
    end else if (cmd.wr && match) begin
      data_nxt = wr_value;
    end
  end

  // Entry contents need no reset; only entries below the count are read.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (cmd.rd && match) ? data_r : '0;

endmodule

/* rtl/core/ordered_word_list.sv */
// Top level of the ordered word list: request decode, the entry count, the
// row of owl_cell instances and the registered result stage.
// Depends on owl_pkg and owl_cell.
`timescale 1ns / 1ps

// Usage
// The block keeps an ordered list of up to CAPACITY 32-bit words. A request
// on the in_ channel (action, index, value) is transferred when in_valid and
// in_ready are both high. Actions are push, pop, replace, insert, delete and
// read; insert, delete, replace and read need an index below the length.
// Every request gives exactly one result on the out_ channel: ok, the word
// read (zero unless a read succeeds) and the length after the request.
// The result is valid in the cycle after the transfer. Throughput is one
// request per cycle while out_ready is high, including insert and delete,
// because every cell of the row loads its neighbor in the same clock edge.
// The result sits in an output register; in_ready is high while that
// register is empty or being drained, so a stalled receiver holds the result
// and stops new requests until out_ready returns.
// A synchronous reset (rst_n low) empties the list and drops any pending
// result. Entry contents are not reset.

module ordered_word_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [owl_pkg::ACT_W-1:0] in_action,
  input  logic [owl_pkg::IDX_W-1:0] in_index,
  input  logic [owl_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [owl_pkg::VAL_W-1:0] out_read_value,
  output logic [owl_pkg::LEN_W-1:0] out_length
);
  import owl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SEL_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_ok_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic [LEN_W-1:0] out_length_r;

  logic             xfer;
  logic             in_range;
  logic             not_full;
  logic             ok;
  logic [SEL_W-1:0] idx_ext;
  logic [SEL_W-1:0] cnt_ext;
  logic [SEL_W-1:0] sel_pos;
  cell_cmd_t        cmd;
  cell_cmd_t        cmd_gated;
  logic [VAL_W-1:0] rd_bus;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [VAL_W-1:0] cell_rd   [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign xfer     = in_valid && in_ready;

  assign idx_ext  = SEL_W'(in_index);
  assign cnt_ext  = SEL_W'(count_r);
  assign in_range = (idx_ext < cnt_ext);
  assign not_full = (count_r < CNT_FULL);

  // Request decode: success, cell command, selected position and new count.
  always_comb begin
    ok        = 1'b0;
    cmd       = '0;
    sel_pos   = idx_ext;
    count_nxt = count_r;
    unique case (action_t'(in_action))
      ACT_PUSH: begin
        ok      = not_full;
        cmd.wr  = not_full;
        sel_pos = cnt_ext;
        if (not_full) begin
          count_nxt = count_r + CNT_ONE;
        end
      end
      ACT_POP: begin
        ok = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - CNT_ONE;
        end
      end
      ACT_REPLACE: begin
        ok     = in_range;
        cmd.wr = in_range;
      end
      ACT_INSERT: begin
        ok      = in_range && not_full;
        cmd.wr  = ok;
        cmd.ins = ok;
        if (ok) begin
          count_nxt = count_r + CNT_ONE;
        end
      end
      ACT_DELETE: begin
        ok      = in_range;
        cmd.del = in_range;
        if (in_range) begin
          count_nxt = count_r - CNT_ONE;
        end
      end
      ACT_READ: begin
        ok     = in_range;
        cmd.rd = in_range;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Cells act only in the cycle of a transfer.
  assign cmd_gated = xfer ? cmd : '0;

  // Row of cells; each one sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    owl_cell #(
      .POS   (i),
      .SEL_W (SEL_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd_gated),
      .sel_pos    (sel_pos),
      .wr_value   (in_value),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero word, so the read bus is an OR.
  always_comb begin
    rd_bus = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (xfer) begin
      count_r <= count_nxt;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_ok_r         <= ok;
      out_read_value_r <= rd_bus;
      out_length_r     <= LEN_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_length     = out_length_r;

endmodule

/* rtl/core/owl_checker.sv */
// Port-level checks for the ordered word list, attached by a bind statement.
// Depends on owl_pkg and on the ordered_word_list top level.
`timescale 1ns / 1ps

module owl_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [owl_pkg::ACT_W-1:0] in_action,
  input logic [owl_pkg::IDX_W-1:0] in_index,
  input logic [owl_pkg::VAL_W-1:0] in_value,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_ok,
  input logic [owl_pkg::VAL_W-1:0] out_read_value,
  input logic [owl_pkg::LEN_W-1:0] out_length
);
  import owl_pkg::*;

  // A waiting request keeps its valid and its fields until it is transferred.
  a_request_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_action)
      && $stable(in_index) && $stable(in_value))
    else $error("request changed while waiting");

  // A failed request never returns a word.
  a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_read_value == '0)
    else $error("failed request returned a nonzero word");

  // An empty or draining result register always takes a new request.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("request channel stalled while result stage was free");

  // The reported length never exceeds the capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127) || (32'(out_length) <= CAPACITY))
    else $error("reported length exceeds capacity");

  // A stalled result holds until it is transferred.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok)
      && $stable(out_read_value) && $stable(out_length))
    else $error("result changed while stalled");

endmodule

bind ordered_word_list owl_checker #(.CAPACITY(CAPACITY)) u_owl_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for ordered_word_list: random and directed requests,
// a scoreboard class that predicts every result, and random stalls on both sides.
// Depends on owl_pkg and the ordered_word_list RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CAPACITY = 64;

  // Action codes outside the defined set; the block must reject them.
  localparam bit [owl_pkg::ACT_W-1:0] ACT_UNKNOWN_LO = 3'd6;
  localparam bit [owl_pkg::ACT_W-1:0] ACT_UNKNOWN_HI = 3'd7;

  // Mix of actions used by one phase of the random stimulus.
  typedef enum int {GROW_MIX, SHRINK_MIX, EVEN_MIX} mix_t;

  typedef struct {
    bit ok;
    bit [owl_pkg::VAL_W-1:0] word;
    bit [owl_pkg::LEN_W-1:0] length;
  } list_result_t;

  typedef struct {
    bit [owl_pkg::ACT_W-1:0] act;
    bit [owl_pkg::IDX_W-1:0] idx;
    bit [owl_pkg::VAL_W-1:0] val;
  } request_t;

  // Keeps a copy of the list, predicts the result of every transferred
  // request and compares the results that come out of the block.
  class word_list_tracker;
    bit [owl_pkg::VAL_W-1:0] words [CAPACITY];
    int unsigned entry_count;
    list_result_t due_results[$];
    int mismatches;

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Applies one transferred request to the list copy and queues its result.
    function void note_request(bit [owl_pkg::ACT_W-1:0] act,
                               bit [owl_pkg::IDX_W-1:0] idx,
                               bit [owl_pkg::VAL_W-1:0] val);
      list_result_t res;
      bit in_range;
      int i;
      res.ok = 1'b0;
      res.word = '0;
      in_range = idx < entry_count;
      case (act)
        owl_pkg::ACT_PUSH: begin
          if (entry_count < CAPACITY) begin
            words[entry_count] = val;
            entry_count++;
            res.ok = 1'b1;
          end
        end
        owl_pkg::ACT_POP: begin
          // Popping an empty list still succeeds.
          if (entry_count > 0) entry_count--;
          res.ok = 1'b1;
        end
        owl_pkg::ACT_REPLACE: begin
          if (in_range) begin
            words[idx] = val;
            res.ok = 1'b1;
          end
        end
        owl_pkg::ACT_INSERT: begin
          if (in_range && entry_count < CAPACITY) begin
            for (i = entry_count; i > idx; i--) words[i] = words[i-1];
            words[idx] = val;
            entry_count++;
            res.ok = 1'b1;
          end
        end
        owl_pkg::ACT_DELETE: begin
          if (in_range) begin
            for (i = idx; i + 1 < entry_count; i++) words[i] = words[i+1];
            entry_count--;
            res.ok = 1'b1;
          end
        end
        owl_pkg::ACT_READ: begin
          if (in_range) begin
            res.word = words[idx];
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.length = entry_count[owl_pkg::LEN_W-1:0];
      due_results.push_back(res);
    endfunction

    // Compares one transferred result with the oldest prediction.
    task check_result(logic ok, logic [owl_pkg::VAL_W-1:0] word,
                      logic [owl_pkg::LEN_W-1:0] length);
      list_result_t exp;
      if (due_results.size() == 0) begin
        flag_mismatch("result arrived with no request outstanding");
        return;
      end
      exp = due_results.pop_front();
      if (ok !== exp.ok)
        flag_mismatch($sformatf("ok %b, predicted %b", ok, exp.ok));
      if (word !== exp.word)
        flag_mismatch($sformatf("read_value %h, predicted %h", word, exp.word));
      if (length !== exp.length)
        flag_mismatch($sformatf("length %0d, predicted %0d", length, exp.length));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [owl_pkg::ACT_W-1:0] in_action = '0;
  logic [owl_pkg::IDX_W-1:0] in_index = '0;
  logic [owl_pkg::VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [owl_pkg::VAL_W-1:0] out_read_value;
  logic [owl_pkg::LEN_W-1:0] out_length;

  bit idle_on = 1'b1;
  word_list_tracker tracker;

  ordered_word_list #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_index(in_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ok(out_ok),
    .out_read_value(out_read_value),
    .out_length(out_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready with random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Handshake signals are stable at the falling edge, so a transfer seen
  // here is the one that the next rising edge completes.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_ok, out_read_value, out_length);
  end

  // Drives one request; called right after a rising edge and returns right
  // after the edge at which the request is transferred.
  task send_request(bit [owl_pkg::ACT_W-1:0] act, bit [owl_pkg::IDX_W-1:0] idx,
                    bit [owl_pkg::VAL_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_index <= idx;
    in_value <= val;
    do @(negedge clk); while (!in_ready);
    tracker.note_request(act, idx, val);
    @(posedge clk);
  endtask

  // Picks a random request, mostly with an index inside the current list.
  function automatic request_t pick_request(mix_t mix);
    request_t req;
    int weights[7];
    int roll;
    int sum;
    int k;
    int unsigned len;
    bit picked;
    len = tracker.entry_count;
    case (mix)
      GROW_MIX:   weights = '{35, 5, 10, 25, 5, 15, 5};
      SHRINK_MIX: weights = '{10, 25, 10, 5, 30, 15, 5};
      default:    weights = '{17, 17, 15, 15, 15, 17, 4};
    endcase
    // The last weight stands for the undefined action codes.
    roll = $urandom_range(0, 99);
    sum = 0;
    picked = 1'b0;
    req.act = ACT_UNKNOWN_LO;
    for (k = 0; k < 7 && !picked; k++) begin
      sum += weights[k];
      if (roll < sum) begin
        picked = 1'b1;
        if (k < 6) req.act = k[owl_pkg::ACT_W-1:0];
        else req.act = 3'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 75 && len > 0) req.idx = 6'($urandom_range(0, len - 1));
    else if (roll < 85 && len < CAPACITY) req.idx = 6'(len);
    else req.idx = 6'($urandom_range(0, CAPACITY - 1));
    roll = $urandom_range(0, 99);
    if (roll < 10) req.val = '0;
    else if (roll < 15) req.val = '1;
    else if (roll < 35) req.val = $urandom_range(0, 255);
    else req.val = $urandom;
    return req;
  endfunction

  initial begin
    request_t req;
    int n;
    int drain_cycles;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-list cases, bad indexes, edges of the word,
    // insert and delete at both ends, and the undefined action codes.
    send_request(owl_pkg::ACT_POP, 0, 32'h0);
    send_request(owl_pkg::ACT_READ, 0, 32'h0);
    send_request(owl_pkg::ACT_INSERT, 0, 32'h1111_1111);
    send_request(owl_pkg::ACT_REPLACE, 0, 32'h2222_2222);
    send_request(owl_pkg::ACT_DELETE, 0, 32'h0);
    send_request(owl_pkg::ACT_PUSH, 0, 32'h0);
    send_request(owl_pkg::ACT_PUSH, 63, 32'hFFFF_FFFF);
    send_request(owl_pkg::ACT_PUSH, 21, 32'h1234_5678);
    send_request(owl_pkg::ACT_READ, 0, 32'h0);
    send_request(owl_pkg::ACT_READ, 2, 32'hFFFF_FFFF);
    send_request(owl_pkg::ACT_READ, 3, 32'h0);
    send_request(owl_pkg::ACT_INSERT, 3, 32'h3333_3333);
    send_request(owl_pkg::ACT_INSERT, 0, 32'hA5A5_A5A5);
    send_request(owl_pkg::ACT_INSERT, 2, 32'h5A5A_5A5A);
    send_request(owl_pkg::ACT_REPLACE, 3, 32'hDEAD_BEEF);
    send_request(owl_pkg::ACT_DELETE, 4, 32'h0);
    send_request(owl_pkg::ACT_DELETE, 0, 32'h0);
    send_request(owl_pkg::ACT_READ, 63, 32'h0);
    send_request(ACT_UNKNOWN_LO, 0, 32'h4444_4444);
    send_request(ACT_UNKNOWN_HI, 1, 32'hFFFF_FFFF);
    send_request(owl_pkg::ACT_READ, 1, 32'h0);
    repeat (4) send_request(owl_pkg::ACT_POP, 0, 32'h0);
    send_request(owl_pkg::ACT_PUSH, 0, 32'h8000_0001);

    // Random part: phases that fill the list, drain it or keep it level.
    for (n = 0; n < 1500; n++) begin
      if (n >= 1300) idle_on = 1'b0;
      case ((n / 150) % 3)
        0: req = pick_request(GROW_MIX);
        1: req = pick_request(EVEN_MIX);
        default: req = pick_request(SHRINK_MIX);
      endcase
      send_request(req.act, req.idx, req.val);
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow a few more cycles.
    drain_cycles = 0;
    while (tracker.due_results.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (tracker.due_results.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.due_results.size()));
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs far less than this.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* ordered_word_list.f */
rtl/core/owl_pkg.sv
rtl/core/owl_cell.sv
rtl/core/ordered_word_list.sv
rtl/core/owl_checker.sv
tb/testbench.sv
